>>> hw/rtl/dce_pkg.sv
// Shared types and constants of the distance countdown estimator.
package dce_pkg;

  // Item kinds; code 3 is unused and ignored
  typedef enum logic [1:0] {
    ACT_PACKET = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Configuration register indexes
  localparam logic CFG_HOLD_LIMIT = 1'b0;
  localparam logic CFG_SPEED_CEIL = 1'b1;

  localparam logic [15:0] HOLD_LIMIT_RST = 16'd10000;
  localparam logic [15:0] SPEED_CEIL_RST = 16'd61440;

  // Speed smoothing weights, 0.7 and 0.3 in units of 1/256
  localparam logic [7:0]  W_OLD      = 8'd179;
  localparam logic [7:0]  W_NEW      = 8'd77;
  localparam logic [24:0] BLEND_HALF = 25'd128;

  // 921600 = 2^12 * 225; the odd factor is divided out by a reciprocal
  // multiply with a 34-bit shift, exact for dividends below 2^26
  localparam logic [7:0]  DIV_ODD   = 8'd225;
  localparam logic [26:0] RECIP_ODD = 27'd76354975;

  // Values that travel with a query down the travel pipeline
  typedef struct packed {
    logic [31:0] anchor;
    logic        stale;
    logic        base;
  } tag_t;

  // Query snapshot taken from the state registers
  typedef struct packed {
    logic [15:0] speed;
    logic [31:0] elapsed;
    tag_t        tag;
  } snap_t;

  // Partial quotients handed to the result stage
  typedef struct packed {
    logic [10:0] qa;
    logic [51:0] my;
    tag_t        tag;
  } mid_t;

endpackage

>>> hw/rtl/dce_state.sv
// Input register, configuration registers, estimator state and query snapshot.
module dce_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [15:0]         maneuver_id_i,
  input  logic                dist_ok_i,
  input  logic [31:0]         dist_m_i,
  input  logic [31:0]         packet_time_ms_i,
  input  logic                speed_ok_i,
  input  logic signed [17:0]  speed_q8_i,
  input  logic [31:0]         query_time_ms_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  output logic                snap_valid_o,
  input  logic                snap_ready_i,
  output dce_pkg::snap_t      snap_o
);
  import dce_pkg::*;

  logic               in_vld_q;
  logic [1:0]         act_q;
  logic [15:0]        man_q;
  logic               dok_q;
  logic [31:0]        dist_q;
  logic [31:0]        ptime_q;
  logic               sok_q;
  logic signed [17:0] spd_q;
  logic [31:0]        now_q;

  logic [15:0] hold_q;
  logic [15:0] ceil_q;

  logic [15:0] last_man_q;
  logic [31:0] last_pt_q;
  logic [31:0] anchor_dist_q;
  logic [31:0] anchor_time_q;
  logic [15:0] sspeed_q;
  logic        base_q;

  logic        is_query;
  logic        leave;
  logic [15:0] speed_clamped;
  logic        fresh;
  logic [24:0] blend_sum;
  logic [31:0] since_pkt;
  logic        stale;

  // Item leaves the input register unless a query waits for the pipeline
  assign is_query     = (act_q == ACT_QUERY);
  assign leave        = in_vld_q && (!is_query || snap_ready_i);
  assign in_ready_o   = !in_vld_q || leave;
  assign snap_valid_o = in_vld_q && is_query;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q   <= action_i;
      man_q   <= maneuver_id_i;
      dok_q   <= dist_ok_i;
      dist_q  <= dist_m_i;
      ptime_q <= packet_time_ms_i;
      sok_q   <= speed_ok_i;
      spd_q   <= speed_q8_i;
      now_q   <= query_time_ms_i;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_LIMIT_RST;
      ceil_q <= SPEED_CEIL_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_HOLD_LIMIT) begin
        hold_q <= cfg_wdata_i;
      end
      if (cfg_index_i == CFG_SPEED_CEIL) begin
        ceil_q <= cfg_wdata_i;
      end
    end
  end

  // Clamp the reported speed to [0, ceiling] and blend it with the filter
  always_comb begin
    if (spd_q[17]) begin
      speed_clamped = '0;
    end else if (spd_q[16:0] > {1'b0, ceil_q}) begin
      speed_clamped = ceil_q;
    end else begin
      speed_clamped = spd_q[15:0];
    end
  end

  assign fresh     = !base_q || (man_q != last_man_q);
  assign blend_sum = 25'(sspeed_q) * 25'(W_OLD) + 25'(speed_clamped) * 25'(W_NEW) + BLEND_HALF;

  // Apply packets and clears as they leave the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_man_q    <= '0;
      last_pt_q     <= '0;
      anchor_dist_q <= '0;
      anchor_time_q <= '0;
      sspeed_q      <= '0;
      base_q        <= 1'b0;
    end else if (leave) begin
      case (act_q)
        ACT_PACKET: begin
          if (dok_q && (!base_q || (dist_q != anchor_dist_q))) begin
            anchor_dist_q <= dist_q;
            anchor_time_q <= ptime_q;
          end
          last_man_q <= man_q;
          last_pt_q  <= ptime_q;
          if (sok_q) begin
            sspeed_q <= fresh ? speed_clamped : blend_sum[23:8];
          end
          base_q <= 1'b1;
        end
        ACT_CLEAR: begin
          last_man_q    <= '0;
          last_pt_q     <= '0;
          anchor_dist_q <= '0;
          anchor_time_q <= '0;
          sspeed_q      <= '0;
          base_q        <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Snapshot for a query: staleness and elapsed time, wrapping
  assign since_pkt = now_q - last_pt_q;
  assign stale     = since_pkt > {16'b0, hold_q};

  always_comb begin
    snap_o.speed      = sspeed_q;
    snap_o.elapsed    = stale ? {16'b0, hold_q} : (now_q - anchor_time_q);
    snap_o.tag.anchor = anchor_dist_q;
    snap_o.tag.stale  = stale || !base_q;
    snap_o.tag.base   = base_q;
  end

endmodule

>>> hw/rtl/dce_travel.sv
// Travel pipeline: speed times elapsed time, then division by 921600.
module dce_travel (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           snap_valid_i,
  output logic           snap_ready_o,
  input  dce_pkg::snap_t snap_i,
  output logic           mid_valid_o,
  input  logic           mid_ready_i,
  output dce_pkg::mid_t  mid_o
);
  import dce_pkg::*;

  logic [4:0]  vld_q;
  logic [4:0]  adv;

  snap_t       snap_q;
  logic [47:0] prod_q;
  tag_t        tag1_q;
  logic [44:0] ma_q;
  logic [17:0] a_q;
  logic [17:0] b_q;
  tag_t        tag2_q;
  logic [25:0] y_q;
  logic [10:0] qa3_q;
  tag_t        tag3_q;
  logic [51:0] my_q;
  logic [10:0] qa4_q;
  tag_t        tag4_q;

  logic [10:0] qa_c;
  logic [17:0] qa_mul;
  logic [17:0] ra_c;

  // Stage may load when empty or when its item moves on
  assign adv[4] = !vld_q[4] || mid_ready_i;
  assign adv[3] = !vld_q[3] || adv[4];
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  assign snap_ready_o = adv[0];
  assign mid_valid_o  = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= snap_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
      if (adv[4]) vld_q[4] <= vld_q[3];
    end
  end

  // High quotient digit and its remainder
  assign qa_c   = ma_q[44:34];
  assign qa_mul = 18'(qa_c) * 18'(DIV_ODD);
  assign ra_c   = a_q - qa_mul;

  // Advance the payload stages
  always_ff @(posedge clk_i) begin
    if (adv[0] && snap_valid_i) begin
      snap_q <= snap_i;
    end
    if (adv[1] && vld_q[0]) begin
      prod_q <= 48'(snap_q.speed) * 48'(snap_q.elapsed);
      tag1_q <= snap_q.tag;
    end
    // Drop the 2^12 factor; split the rest into high and low 18 bits
    if (adv[2] && vld_q[1]) begin
      ma_q   <= 45'(prod_q[47:30]) * 45'(RECIP_ODD);
      a_q    <= prod_q[47:30];
      b_q    <= prod_q[29:12];
      tag2_q <= tag1_q;
    end
    if (adv[3] && vld_q[2]) begin
      y_q    <= {ra_c[7:0], b_q};
      qa3_q  <= qa_c;
      tag3_q <= tag2_q;
    end
    if (adv[4] && vld_q[3]) begin
      my_q   <= 52'(y_q) * 52'(RECIP_ODD);
      qa4_q  <= qa3_q;
      tag4_q <= tag3_q;
    end
  end

  always_comb begin
    mid_o.qa  = qa4_q;
    mid_o.my  = my_q;
    mid_o.tag = tag4_q;
  end

endmodule

>>> hw/rtl/dce_result.sv
// Result stage: travelled distance, remaining distance and output register.
module dce_result (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_valid_i,
  output logic          mid_ready_o,
  input  dce_pkg::mid_t mid_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   remaining_m_o,
  output logic          is_stale_o,
  output logic          baseline_seen_o
);
  import dce_pkg::*;

  logic        out_vld_q;
  logic [31:0] rem_q;
  logic        stale_q;
  logic        base_q;

  logic [17:0] qy;
  logic [28:0] travelled;
  logic [31:0] rem_c;
  logic        adv;

  // Join the quotient digits and subtract from the anchor, floored at 0
  assign qy        = mid_i.my[51:34];
  assign travelled = {mid_i.qa, 18'b0} + 29'(qy);

  always_comb begin
    if (!mid_i.tag.base || (32'(travelled) >= mid_i.tag.anchor)) begin
      rem_c = '0;
    end else begin
      rem_c = mid_i.tag.anchor - 32'(travelled);
    end
  end

  assign adv         = !out_vld_q || !out_stall_i;
  assign mid_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mid_valid_i;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (adv && mid_valid_i) begin
      rem_q   <= rem_c;
      stale_q <= mid_i.tag.stale;
      base_q  <= mid_i.tag.base;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign remaining_m_o   = rem_q;
  assign is_stale_o      = stale_q;
  assign baseline_seen_o = base_q;

endmodule

>>> hw/rtl/distance_countdown_estimator.sv
// Top level of the distance countdown estimator.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   input   | in_valid_i / in_stall_o   | action, maneuver, distance, times, speed
//   output  | out_valid_o / out_stall_i | remaining_m, is_stale, baseline_seen
//   config  | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One item per cycle unless a query waits behind a stalled output. The
// travel depth is set by the speed-times-time multiply and the two
// reciprocal multiplies that divide by 921600.
// Packets and clears update the state as they leave the input register and
// give no result. Reset clears the estimator state and the valid flags; the configuration registers return to defaults.
// Stages hold independently, so items are still taken while a result waits.
module distance_countdown_estimator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [15:0]        maneuver_id_i,
  input  logic               dist_ok_i,
  input  logic [31:0]        dist_m_i,
  input  logic [31:0]        packet_time_ms_i,
  input  logic               speed_ok_i,
  input  logic signed [17:0] speed_q8_i,
  input  logic [31:0]        query_time_ms_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        remaining_m_o,
  output logic               is_stale_o,
  output logic               baseline_seen_o
);
  import dce_pkg::*;

  logic  in_ready;
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;
  logic  mid_valid;
  logic  mid_ready;
  mid_t  mid;

  assign in_stall_o = !in_ready;

  dce_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready),
    .action_i         (action_i),
    .maneuver_id_i    (maneuver_id_i),
    .dist_ok_i        (dist_ok_i),
    .dist_m_i         (dist_m_i),
    .packet_time_ms_i (packet_time_ms_i),
    .speed_ok_i       (speed_ok_i),
    .speed_q8_i       (speed_q8_i),
    .query_time_ms_i  (query_time_ms_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .snap_valid_o     (snap_valid),
    .snap_ready_i     (snap_ready),
    .snap_o           (snap)
  );

  dce_travel u_travel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .mid_valid_o  (mid_valid),
    .mid_ready_i  (mid_ready),
    .mid_o        (mid)
  );

  dce_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mid_valid_i     (mid_valid),
    .mid_ready_o     (mid_ready),
    .mid_i           (mid),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .remaining_m_o   (remaining_m_o),
    .is_stale_o      (is_stale_o),
    .baseline_seen_o (baseline_seen_o)
  );

  // A result without a baseline is stale and reports zero distance
  a_no_base_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !baseline_seen_o |-> is_stale_o && (remaining_m_o == 32'd0))
    else $error("result without baseline is not stale zero");

  // Input stalls only behind a query the travel pipeline cannot take
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> snap_valid && !snap_ready)
    else $error("input stalled without a blocked query");

  // Last travel stage held only while the output is held
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid && !mid_ready |-> out_valid_o && out_stall_i)
    else $error("travel pipeline held while output free");

endmodule
